// File: rtl/core/kdlp_pkg.sv
package kdlp_pkg;

  localparam int unsigned CFG_DW = 16;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PIN_W  = 8;

  localparam logic [7:0]  ENABLE_RST   = 8'hFF;
  localparam logic [7:0]  POLARITY_RST = 8'h00;
  localparam logic [7:0]  PERIOD_RST   = 8'd10;
  localparam logic [15:0] LIMIT_RST    = 16'd2000;

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_POLARITY = 2'd1,
    REG_PERIOD   = 2'd2,
    REG_LIMIT    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_UP            = 3'd0,
    PH_PRESS_BOUNCE  = 3'd1,
    PH_DOWN          = 3'd2,
    PH_RELEASE_BOUNCE = 3'd3,
    PH_LONG_DOWN     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } seq_state_e;

  // result of one key step from the shared unit
  typedef struct packed {
    phase_e              phase;
    logic [TIME_W-1:0]   ptime;
    logic                rel;
    logic                lng;
    logic                held;
  } key_upd_t;

endpackage

// File: rtl/core/kdlp_key_unit.sv
// One key step: phase transition, saturating press-time add, long compare.
module kdlp_key_unit (
  input  kdlp_pkg::phase_e                 phase_i,
  input  logic [kdlp_pkg::TIME_W-1:0]      ptime_i,
  input  logic                             qual_i,
  input  logic [7:0]                       period_i,
  input  logic [kdlp_pkg::TIME_W-1:0]      limit_i,
  output kdlp_pkg::key_upd_t               upd_o
);

  logic [kdlp_pkg::TIME_W:0]   sum;
  logic [kdlp_pkg::TIME_W-1:0] sat;

  assign sum = {1'b0, ptime_i} + {{(kdlp_pkg::TIME_W - 7){1'b0}}, period_i};
  assign sat = sum[kdlp_pkg::TIME_W] ? {kdlp_pkg::TIME_W{1'b1}} : sum[kdlp_pkg::TIME_W-1:0];

  always_comb begin
    upd_o.phase = phase_i;
    upd_o.ptime = ptime_i;
    upd_o.rel   = 1'b0;
    upd_o.lng   = 1'b0;
    case (phase_i)
      kdlp_pkg::PH_PRESS_BOUNCE: begin
        if (qual_i) begin
          upd_o.phase = kdlp_pkg::PH_DOWN;
          upd_o.ptime = '0;
        end else begin
          upd_o.phase = kdlp_pkg::PH_UP;
        end
      end
      kdlp_pkg::PH_DOWN: begin
        if (qual_i) begin
          upd_o.ptime = sat;
          if (sat > limit_i) begin
            upd_o.phase = kdlp_pkg::PH_LONG_DOWN;
            upd_o.lng   = 1'b1;
          end
        end else begin
          upd_o.phase = kdlp_pkg::PH_RELEASE_BOUNCE;
        end
      end
      kdlp_pkg::PH_RELEASE_BOUNCE: begin
        if (qual_i) begin
          upd_o.ptime = sat;
          upd_o.phase = kdlp_pkg::PH_DOWN;
        end else begin
          upd_o.phase = kdlp_pkg::PH_UP;
          upd_o.rel   = 1'b1;
        end
      end
      kdlp_pkg::PH_LONG_DOWN: begin
        if (qual_i) begin
          upd_o.ptime = sat;
        end else begin
          upd_o.phase = kdlp_pkg::PH_RELEASE_BOUNCE;
        end
      end
      default: begin
        upd_o.phase = qual_i ? kdlp_pkg::PH_PRESS_BOUNCE : kdlp_pkg::PH_UP;
      end
    endcase
    upd_o.held = (upd_o.phase == kdlp_pkg::PH_DOWN) ||
                 (upd_o.phase == kdlp_pkg::PH_LONG_DOWN);
  end

endmodule

// File: rtl/core/key_debounce_long_press.sv
// Flow: a scan beat is taken in IDLE, SCAN then steps through the keys, FLUSH moves the events out.
// A scan beat is taken only in IDLE, so the next one waits until FLUSH is done; the
//   single key-step unit visits one key per cycle, and FLUSH stalls while the previous result is not taken.
// A new scan beat is taken while the previous result still waits in the output register.
// Reset (rst_ni low, async): all keys up, press times and qualified levels zero,
//   registers at enable=FF, polarity=00, period=10, limit=2000; no result pending.
module key_debounce_long_press #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [kdlp_pkg::CFG_DW-1:0]   cfg_data_i,
  // scan tick input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    raw_levels_i,
  // event output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    release_events_o,
  output logic [7:0]                    long_events_o,
  output logic [7:0]                    held_keys_o
);

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]                  enable_q;
  logic [7:0]                  polarity_q;
  logic [7:0]                  period_q;
  logic [kdlp_pkg::TIME_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= kdlp_pkg::ENABLE_RST;
      polarity_q <= kdlp_pkg::POLARITY_RST;
      period_q   <= kdlp_pkg::PERIOD_RST;
      limit_q    <= kdlp_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      case (kdlp_pkg::cfg_reg_e'(cfg_idx_i))
        kdlp_pkg::REG_ENABLE:   enable_q   <= cfg_data_i[7:0];
        kdlp_pkg::REG_POLARITY: polarity_q <= cfg_data_i[7:0];
        kdlp_pkg::REG_PERIOD:   period_q   <= cfg_data_i[7:0];
        kdlp_pkg::REG_LIMIT:    limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE -> SCAN (one key per cycle) -> FLUSH (load output register)
  // ---------------------------------------------------------------------------
  kdlp_pkg::seq_state_e state_q, state_d;
  logic [KW-1:0]        idx_q, idx_d;
  logic                 in_fire;
  logic                 out_load;
  logic                 scan_en;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    scan_en    = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      kdlp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = kdlp_pkg::ST_SCAN;
          idx_d   = '0;
        end
      end
      kdlp_pkg::ST_SCAN: begin
        scan_en = 1'b1;
        if (idx_q == LAST_KEY) begin
          state_d = kdlp_pkg::ST_FLUSH;
        end else begin
          idx_d = idx_q + KW'(1);
        end
      end
      kdlp_pkg::ST_FLUSH: begin
        // wait here only if the previous result has not been taken yet
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = kdlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kdlp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kdlp_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-key state, one entry per key, read and written at idx_q
  // ---------------------------------------------------------------------------
  kdlp_pkg::phase_e            phase_q [NUM_KEYS];
  logic [kdlp_pkg::TIME_W-1:0] ptime_q [NUM_KEYS];
  logic [NUM_KEYS-1:0]         qual_q;

  logic [7:0] raw_q;
  logic [5:0] idx_ext;
  logic [2:0] pin;
  logic       has_pin;
  logic       qual_cur;

  // only the first eight keys have a pin, enable and polarity bit
  assign idx_ext = 6'(idx_q);
  assign pin     = idx_ext[2:0];
  assign has_pin = (idx_ext < 6'(kdlp_pkg::PIN_W));

  always_comb begin
    qual_cur = qual_q[idx_q];
    if (has_pin && enable_q[pin]) begin
      qual_cur = (raw_q[pin] == polarity_q[pin]);
    end
  end

  kdlp_pkg::key_upd_t upd;

  kdlp_key_unit u_key_unit (
    .phase_i  (phase_q[idx_q]),
    .ptime_i  (ptime_q[idx_q]),
    .qual_i   (qual_cur),
    .period_i (period_q),
    .limit_i  (limit_q),
    .upd_o    (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_q[k] <= kdlp_pkg::PH_UP;
        ptime_q[k] <= '0;
      end
      qual_q <= '0;
    end else if (scan_en) begin
      phase_q[idx_q] <= upd.phase;
      ptime_q[idx_q] <= upd.ptime;
      qual_q[idx_q]  <= qual_cur;
    end
  end

  // event accumulators, cleared at each accepted beat
  logic [7:0] acc_rel_q, acc_lng_q, acc_held_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q      <= raw_levels_i;
      acc_rel_q  <= '0;
      acc_lng_q  <= '0;
      acc_held_q <= '0;
    end else if (scan_en && has_pin) begin
      acc_rel_q[pin]  <= upd.rel;
      acc_lng_q[pin]  <= upd.lng;
      acc_held_q[pin] <= upd.held;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      release_events_o <= acc_rel_q;
      long_events_o    <= acc_lng_q;
      held_keys_o      <= acc_held_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == kdlp_pkg::ST_SCAN) && (idx_q == '0))
    else $error("scan did not start at key zero");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_KEY)
    else $error("key index out of range");

  a_rel_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((release_events_o & held_keys_o) == 8'h00))
    else $error("released key reported as held");

  a_long_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((long_events_o & ~held_keys_o) == 8'h00))
    else $error("long event on key not held");

endmodule
